// ----- rtl/lfe_pkg.sv -----
// Shared constants, command codes and control structs of the life board.
`default_nettype none

package lfe_pkg;

   // Fixed widths of the word fields and the configuration registers.
   localparam int CMD_W = 2;
   localparam int XY_W  = 6;
   localparam int CFG_W = 7;
   localparam int NBR_W = 4;

   // Both size registers come out of reset at 64.
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // Neighbour counts of rule B3/S23.
   localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
   localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 2'd0,
      CMD_TOGGLE = 2'd1,
      CMD_STEP   = 2'd2
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_BOARD_WIDTH  = 1'b0,
      CSR_BOARD_HEIGHT = 1'b1
   } csr_index_type;

   // Control of one row cell of the chain.
   typedef struct packed {
      logic shift;
      logic flip;
   } cell_ctl_type;

   // Control of the three-row window.
   typedef struct packed {
      logic clear;
      logic advance;
   } win_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/lfe_req_if.sv -----
// Command channel of the life board: valid, ready and the command word.
`default_nettype none

interface lfe_req_if
   import lfe_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [XY_W-1:0]  x_coord;
   logic [XY_W-1:0]  y_coord;

   modport source (output valid, output command, output x_coord, output y_coord,
                   input ready);
   modport sink   (input valid, input command, input x_coord, input y_coord,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/lfe_rsp_if.sv -----
// Result channel of the life board: valid, ready and the result word.
`default_nettype none

interface lfe_rsp_if;
   logic valid;
   logic ready;
   logic cell_alive;
   logic range_error;

   modport source (output valid, output cell_alive, output range_error,
                   input ready);
   modport sink   (input valid, input cell_alive, input range_error,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/lfe_row_cell.sv -----
// One row of the board: holds the row, shifts it along the chain or flips one bit.
`default_nettype none

module lfe_row_cell
   import lfe_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_ctl_type     ctl,
   input  wire logic [WIDTH-1:0] shift_in,
   input  wire logic [WIDTH-1:0] col_sel,
   output logic [WIDTH-1:0]      row
);

   logic [WIDTH-1:0] row_ff;
   logic [WIDTH-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      if (ctl.shift) begin
         row_in = shift_in;
      end else if (ctl.flip) begin
         row_in = row_ff ^ col_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row = row_ff;

endmodule

`default_nettype wire

// ----- rtl/lfe_gen_unit.sv -----
// Three-row window and the B3/S23 rule applied to every column of the middle row.
`default_nettype none

module lfe_gen_unit
   import lfe_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire win_ctl_type      ctl,
   input  wire logic [WIDTH-1:0] below,
   input  wire logic [WIDTH-1:0] col_mask,
   output logic [WIDTH-1:0]      next_row
);

   logic [WIDTH-1:0] prev_ff, prev_in;
   logic [WIDTH-1:0] cur_ff, cur_in;
   logic [WIDTH+1:0] p_pad, c_pad, b_pad;
   logic [WIDTH-1:0] life;

   always_comb begin
      prev_in = prev_ff;
      cur_in  = cur_ff;
      if (ctl.clear) begin
         prev_in = '0;
         cur_in  = '0;
      end else if (ctl.advance) begin
         prev_in = cur_ff;
         cur_in  = below;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
   end

   // A dead column on either side stands for the edge of the board.
   assign p_pad = {1'b0, prev_ff, 1'b0};
   assign c_pad = {1'b0, cur_ff, 1'b0};
   assign b_pad = {1'b0, below, 1'b0};

   for (genvar c = 0; c < WIDTH; c++) begin : g_col
      logic [NBR_W-1:0] count;
      assign count = NBR_W'(p_pad[c]) + NBR_W'(p_pad[c+1]) + NBR_W'(p_pad[c+2])
                   + NBR_W'(c_pad[c]) + NBR_W'(c_pad[c+2])
                   + NBR_W'(b_pad[c]) + NBR_W'(b_pad[c+1]) + NBR_W'(b_pad[c+2]);
      assign life[c] = (count == BIRTH_COUNT)
                     | (c_pad[c+1] & (count == SURVIVE_COUNT));
   end

   assign next_row = life & col_mask;

endmodule

`default_nettype wire

// ----- rtl/life_cellular_automaton_board.sv -----
// Top level of the life board: row chain, generation window, command control.
// A read or toggle word gives its result the cycle after acceptance; one such word per cycle
// while each result is taken. A step word holds off new words until its sweep has moved
// every row of the chain once through the three-row window.
// Synchronous active-high reset clears every cell to dead and both size registers to 64.
// No clearing pass is needed: the board is usable in the first cycle after reset.
`default_nettype none

module life_cellular_automaton_board
   import lfe_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   lfe_req_if.sink               req_chan,
   lfe_rsp_if.source             rsp_chan,
   input  wire logic             csr_write_en,
   input  wire logic [0:0]       csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   // Widths that follow from the board dimensions.
   localparam int XI = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YI = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int SWW = (CFG_W > WW) ? CFG_W : WW;
   localparam int SWH = (CFG_W > HW) ? CFG_W : HW;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_STEP = 2'b10
   } state_type;

   // Configuration registers.
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_BOARD_WIDTH:  width_in  = csr_wdata;
            CSR_BOARD_HEIGHT: height_in = csr_wdata;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // The active area is the register value saturated to the board's size.
   logic [SWW-1:0] eff_w;
   logic [SWH-1:0] eff_h_wide;
   logic [HW-1:0]  eff_h;

   assign eff_w = (SWW'(width_ff) > SWW'(MAX_WIDTH)) ? SWW'(MAX_WIDTH) : SWW'(width_ff);
   assign eff_h_wide = (SWH'(height_ff) > SWH'(MAX_HEIGHT)) ? SWH'(MAX_HEIGHT)
                                                            : SWH'(height_ff);
   assign eff_h = HW'(eff_h_wide);

   // Columns inside the active area; everything else reads as dead.
   logic [MAX_WIDTH-1:0] col_mask;
   for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_mask
      assign col_mask[c] = (SWW'(c) < eff_w);
   end

   // Control state.
   state_type      state_ff, state_in;
   logic [HW-1:0]  sweep_ff, sweep_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_alive_ff, rsp_alive_in;
   logic           rsp_err_ff, rsp_err_in;

   logic           req_fire;
   logic           is_read, is_toggle, is_step;
   logic           in_range;
   logic [XI-1:0]  x_idx;
   logic [YI-1:0]  y_idx;
   logic [MAX_WIDTH-1:0] col_sel;
   logic [MAX_WIDTH-1:0] sel_row;
   logic           old_bit;
   logic           sweeping;
   logic           sweep_last;

   // A new word is taken whenever the block is idle and the result register is free,
   // or is being emptied in this very cycle.
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire  = req_chan.valid && req_chan.ready;

   assign is_read   = (req_chan.command == CMD_READ);
   assign is_toggle = (req_chan.command == CMD_TOGGLE);
   assign is_step   = (req_chan.command == CMD_STEP);

   assign in_range = (SWW'(req_chan.x_coord) < eff_w) && (SWH'(req_chan.y_coord) < eff_h_wide);
   assign x_idx    = XI'(req_chan.x_coord);
   assign y_idx    = YI'(req_chan.y_coord);
   assign col_sel  = {{(MAX_WIDTH-1){1'b0}}, 1'b1} << x_idx;

   assign sweeping   = (state_ff == ST_STEP);
   assign sweep_last = (sweep_ff == HW'(MAX_HEIGHT));

   // The chain of row cells. Cell 0 is the head: during a sweep its row leaves towards
   // the window, every cell takes the row of its lower neighbour, and the freshly
   // computed row enters at the tail. After MAX_HEIGHT + 1 shifts the rows are back in
   // their own places, now holding the new generation.
   logic [MAX_WIDTH-1:0] rows [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] tail_row;

   for (genvar r = 0; r < MAX_HEIGHT; r++) begin : g_row
      cell_ctl_type         ctl;
      logic [MAX_WIDTH-1:0] shift_in;

      assign ctl.shift = sweeping;
      assign ctl.flip  = req_fire && is_toggle && in_range && (y_idx == YI'(r));

      if (r == MAX_HEIGHT - 1) begin : g_tail
         assign shift_in = tail_row;
      end else begin : g_body
         assign shift_in = rows[r+1];
      end

      lfe_row_cell #(
         .WIDTH (MAX_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .shift_in (shift_in),
         .col_sel  (col_sel),
         .row      (rows[r])
      );
   end

   // Sweep cycle k brings old row k to the window as the row below, while the window
   // holds rows k-2 and k-1; the rule then yields new row k-1. Rows at or beyond the
   // active height count as dead, and a new row beyond it is cleared. The row made in
   // the first cycle of the sweep has no meaning and falls off the head at the end.
   win_ctl_type          win_ctl;
   logic [MAX_WIDTH-1:0] below_row;
   logic [MAX_WIDTH-1:0] gen_row;

   assign win_ctl.clear   = req_fire && is_step;
   assign win_ctl.advance = sweeping;
   assign below_row = (sweep_ff < eff_h) ? (rows[0] & col_mask) : '0;
   assign tail_row  = (sweep_ff <= eff_h) ? gen_row : '0;

   lfe_gen_unit #(
      .WIDTH (MAX_WIDTH)
   ) u_gen (
      .clock    (clock),
      .ctl      (win_ctl),
      .below    (below_row),
      .col_mask (col_mask),
      .next_row (gen_row)
   );

   // Single cell read for the read and toggle commands.
   assign sel_row = rows[y_idx];
   assign old_bit = sel_row[x_idx];

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_alive_in = rsp_alive_ff;
      rsp_err_in   = rsp_err_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_step) begin
                  state_in = ST_STEP;
                  sweep_in = '0;
               end else begin
                  // Read, toggle and the unused code all answer without a sweep.
                  rsp_valid_in = 1'b1;
                  rsp_alive_in = (is_read || is_toggle) && in_range && (old_bit ^ is_toggle);
                  rsp_err_in   = (is_read || is_toggle) && !in_range;
               end
            end
         end
         ST_STEP: begin
            sweep_in = sweep_ff + HW'(1);
            if (sweep_last) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_alive_in = 1'b0;
               rsp_err_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= CFG_RESET;
         height_ff    <= CFG_RESET;
         state_ff     <= ST_IDLE;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result word itself needs no reset; it only shows under valid.
   always_ff @(posedge clock) begin
      rsp_alive_ff <= rsp_alive_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cell_alive  = rsp_alive_ff;
   assign rsp_chan.range_error = rsp_err_ff;

endmodule

`default_nettype wire
